[src/tlik_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared types, widths and the whole-degree tangent table for the two-link
// inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package tlik_pkg;

  localparam int LINK_W  = 14;
  localparam int CFG_W   = 14;
  localparam int ANG_W   = 10;
  localparam int ELB_W   = 9;
  localparam int D_W     = 58;
  localparam int S_W     = 29;
  localparam int K_W     = 7;
  localparam int TAN_W   = 20;
  localparam int QAT_LAT = 2 * K_W + 2;

  localparam logic [LINK_W-1:0] UPPER_RESET = 14'd1720;
  localparam logic [LINK_W-1:0] LOWER_RESET = 14'd2540;
  localparam logic [13:0]       TAN_SCALE   = 14'd10000;
  localparam logic [K_W-1:0]    TAN_MAX_K   = 7'd90;
  localparam logic signed [ANG_W-1:0] ANG_180 = 10'sd180;

  typedef enum logic [0:0] {
    CFG_UPPER = 1'b0,
    CFG_LOWER = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic yneg;
    logic xneg;
    logic xzero;
  } qsgn_t;

  localparam logic [TAN_W-1:0] TAN_E4 [0:90] = '{
    20'd0, 20'd175, 20'd349, 20'd524, 20'd699, 20'd875, 20'd1051, 20'd1228,
    20'd1405, 20'd1584, 20'd1763, 20'd1944, 20'd2126, 20'd2309, 20'd2493,
    20'd2679, 20'd2867, 20'd3057, 20'd3249, 20'd3443, 20'd3640, 20'd3839,
    20'd4040, 20'd4245, 20'd4452, 20'd4663, 20'd4877, 20'd5095, 20'd5317,
    20'd5543, 20'd5774, 20'd6009, 20'd6249, 20'd6494, 20'd6745, 20'd7002,
    20'd7265, 20'd7536, 20'd7813, 20'd8098, 20'd8391, 20'd8693, 20'd9004,
    20'd9325, 20'd9657, 20'd10000, 20'd10355, 20'd10724, 20'd11106, 20'd11504,
    20'd11918, 20'd12349, 20'd12799, 20'd13270, 20'd13764, 20'd14281, 20'd14826,
    20'd15399, 20'd16003, 20'd16643, 20'd17321, 20'd18040, 20'd18807, 20'd19626,
    20'd20503, 20'd21445, 20'd22460, 20'd23559, 20'd24751, 20'd26051, 20'd27475,
    20'd29042, 20'd30777, 20'd32709, 20'd34874, 20'd37321, 20'd40108, 20'd43315,
    20'd47046, 20'd51446, 20'd56713, 20'd63138, 20'd71154, 20'd81443, 20'd95144,
    20'd114301, 20'd143007, 20'd190811, 20'd286363, 20'd572900, 20'd572910
  };

endpackage

`default_nettype wire

[src/two_link_inverse_kinematics.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics
// Elbow-down inverse kinematics of a planar two-link arm, whole-degree angles.
//
//   port group  dir  handshake          payload
//   in_         in   in_valid/in_stall  in_target_x, in_target_y
//   out_        out  out_valid/out_stall out_shoulder_angle, out_elbow_angle,
//                                       out_unreachable
//   cfg_        in   cfg_we             cfg_index, cfg_data
//
// One transfer per cycle sustained while out_stall stays low. The pipeline is
// 6 front stages, 29 square-root stages (one root bit each), 16 atan2 stages
// (7 table-search bits, two stages each) and the output register.
// Synchronous active-low reset clears valid state; links reset to 1720/2540.
// A two-entry output buffer holds results under out_stall; in_stall rises
// only when its spare entry is full, and then the whole pipeline holds.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics
  import tlik_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_target_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_target_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [ANG_W-1:0]            out_shoulder_angle,
  output logic signed [ELB_W-1:0]            out_elbow_angle,
  output logic                               out_unreachable,
  input  wire logic                          cfg_we,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_data
);

  localparam int CW     = COORD_WIDTH;
  localparam int NW     = (2*CW > 30) ? 2*CW : 30;
  localparam int SIDE_W = 1 + 2*NW + 4 + 2*CW + 2;

  logic [LINK_W-1:0]   l1_r, l2_r;
  logic [2*LINK_W-1:0] a_r, b_r, p_r;
  logic [2*LINK_W:0]   ls_r;
  logic                en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r <= UPPER_RESET;
      l2_r <= LOWER_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_UPPER: l1_r <= cfg_data;
        CFG_LOWER: l2_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= l1_r * l1_r;
    b_r  <= l2_r * l2_r;
    p_r  <= l1_r * l2_r;
    ls_r <= (2*LINK_W+1)'(a_r) + (2*LINK_W+1)'(b_r);
  end

  logic                pv;
  logic [D_W-1:0]      pd;
  logic                preach, pnz, pnn, pmz, pmn, pxn, pyn;
  logic [NW-1:0]       pnmag, pmmag;
  logic [CW-1:0]       pmx, pmy;

  tlik_prep #(.CW(CW)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (in_valid),
    .x_in     (in_target_x),
    .y_in     (in_target_y),
    .a_in     (a_r),
    .b_in     (b_r),
    .ls_in    (ls_r),
    .den_in   ({p_r, 1'b0}),
    .v_out    (pv),
    .d_out    (pd),
    .reach_out(preach),
    .nmag_out (pnmag),
    .nzero_out(pnz),
    .nneg_out (pnn),
    .mmag_out (pmmag),
    .mzero_out(pmz),
    .mneg_out (pmn),
    .mx_out   (pmx),
    .my_out   (pmy),
    .xneg_out (pxn),
    .yneg_out (pyn)
  );

  logic              sv;
  logic [S_W-1:0]    sroot;
  logic [SIDE_W-1:0] sside;
  logic              sreach, snz, snn, smz, smn, sxn, syn;
  logic [NW-1:0]     snmag, smmag;
  logic [CW-1:0]     smx, smy;

  tlik_isqrt #(.SIDE_W(SIDE_W)) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (pv),
    .d_in    (pd),
    .side_in ({preach, pnmag, pnz, pnn, pmmag, pmz, pmn, pmx, pmy, pxn, pyn}),
    .v_out   (sv),
    .root_out(sroot),
    .side_out(sside)
  );

  assign {sreach, snmag, snz, snn, smmag, smz, smn, smx, smy, sxn, syn} = sside;

  logic                    ev;
  logic signed [ANG_W-1:0] elb_a, gam_a, base_a;

  tlik_qatan #(.YW(S_W), .XW(NW)) u_elbow (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (en),
    .v_in (sv),
    .ymag (sroot),
    .xmag (snmag),
    .sgn  ('{yneg: 1'b1, xneg: snn, xzero: snz}),
    .v_out(ev),
    .ang  (elb_a)
  );

  tlik_qatan #(.YW(S_W), .XW(NW)) u_gamma (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (en),
    .v_in (sv),
    .ymag (sroot),
    .xmag (smmag),
    .sgn  ('{yneg: 1'b1, xneg: smn, xzero: smz}),
    .v_out(),
    .ang  (gam_a)
  );

  tlik_qatan #(.YW(CW), .XW(CW)) u_base (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (en),
    .v_in (sv),
    .ymag (smy),
    .xmag (smx),
    .sgn  ('{yneg: syn, xneg: sxn, xzero: (smx == '0)}),
    .v_out(),
    .ang  (base_a)
  );

  logic reach_r [0:QAT_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      reach_r[0] <= sreach;
      for (int i = 1; i < QAT_LAT; i++) begin
        reach_r[i] <= reach_r[i-1];
      end
    end
  end

  logic                    arrive;
  logic signed [ANG_W:0]   sh_diff;
  logic signed [ANG_W-1:0] sh_w;
  logic signed [ELB_W-1:0] el_w;
  logic                    un_w;

  assign arrive  = ev & en;
  assign sh_diff = (ANG_W+1)'(base_a) - (ANG_W+1)'(gam_a);
  assign sh_w    = sh_diff[ANG_W-1:0];
  assign el_w    = elb_a[ELB_W-1:0];
  assign un_w    = ~reach_r[QAT_LAT-1];

  logic                    out_valid_r, skid_full_r;
  logic signed [ANG_W-1:0] out_sh_r, skid_sh_r;
  logic signed [ELB_W-1:0] out_el_r, skid_el_r;
  logic                    out_un_r, skid_un_r;

  assign en = ~skid_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_full_r) begin
        out_valid_r <= 1'b1;
        skid_full_r <= 1'b0;
      end else begin
        out_valid_r <= arrive;
      end
    end else if (arrive) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_full_r) begin
        out_sh_r <= skid_sh_r;
        out_el_r <= skid_el_r;
        out_un_r <= skid_un_r;
      end else begin
        out_sh_r <= sh_w;
        out_el_r <= el_w;
        out_un_r <= un_w;
      end
    end else if (arrive) begin
      skid_sh_r <= sh_w;
      skid_el_r <= el_w;
      skid_un_r <= un_w;
    end
  end

  assign in_stall           = skid_full_r;
  assign out_valid          = out_valid_r;
  assign out_shoulder_angle = out_sh_r;
  assign out_elbow_angle    = out_el_r;
  assign out_unreachable    = out_un_r;

endmodule

`default_nettype wire

[src/tlik_prep.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_prep
// Front stages: coordinate magnitudes, squares, cosine numerator and gamma
// denominator, reach test and the radicand den^2 - num^2.
// ----------------------------------------------------------------------------
module tlik_prep
  import tlik_pkg::*;
#(
  parameter int CW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 v_in,
  input  wire logic signed [CW-1:0] x_in,
  input  wire logic signed [CW-1:0] y_in,
  input  wire logic [2*LINK_W-1:0]  a_in,
  input  wire logic [2*LINK_W-1:0]  b_in,
  input  wire logic [2*LINK_W:0]    ls_in,
  input  wire logic [2*LINK_W:0]    den_in,
  output logic                      v_out,
  output logic [D_W-1:0]            d_out,
  output logic                      reach_out,
  output logic [((2*CW > 30) ? 2*CW : 30)-1:0] nmag_out,
  output logic                      nzero_out,
  output logic                      nneg_out,
  output logic [((2*CW > 30) ? 2*CW : 30)-1:0] mmag_out,
  output logic                      mzero_out,
  output logic                      mneg_out,
  output logic [CW-1:0]             mx_out,
  output logic [CW-1:0]             my_out,
  output logic                      xneg_out,
  output logic                      yneg_out
);

  localparam int NW = (2*CW > 30) ? 2*CW : 30;

  logic            v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [CW-1:0]   mx1_r, my1_r, mx2_r, my2_r, mx3_r, my3_r, mx4_r, my4_r;
  logic [CW-1:0]   mx5_r, my5_r, mx6_r, my6_r;
  logic            xn1_r, yn1_r, xn2_r, yn2_r, xn3_r, yn3_r, xn4_r, yn4_r;
  logic            xn5_r, yn5_r, xn6_r, yn6_r;
  logic [2*CW-1:0] sqx2_r, sqy2_r;
  logic [NW-1:0]   sq3_r;
  logic [NW-1:0]   nmag4_r, mmag4_r, nmag5_r, mmag5_r, nmag6_r, mmag6_r;
  logic            nz4_r, nn4_r, mz4_r, mn4_r, nz5_r, nn5_r, mz5_r, mn5_r;
  logic            nz6_r, nn6_r, mz6_r, mn6_r;
  logic            reach5_r, reach6_r;
  logic [S_W-1:0]  dm5_r;
  logic [S_W:0]    dp5_r;
  logic [D_W-1:0]  d6_r;
  logic [NW-1:0]   ls_w, sa_w, b_w;
  logic [2*S_W:0]  prod_w;

  assign ls_w   = NW'(ls_in);
  assign b_w    = NW'(b_in);
  assign sa_w   = sq3_r + NW'(a_in);
  assign prod_w = dm5_r * dp5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xn1_r <= x_in[CW-1];
      yn1_r <= y_in[CW-1];
      mx1_r <= x_in[CW-1] ? CW'(-x_in) : x_in;
      my1_r <= y_in[CW-1] ? CW'(-y_in) : y_in;

      sqx2_r <= mx1_r * mx1_r;
      sqy2_r <= my1_r * my1_r;
      mx2_r <= mx1_r; my2_r <= my1_r; xn2_r <= xn1_r; yn2_r <= yn1_r;

      sq3_r <= NW'(sqx2_r) + NW'(sqy2_r);
      mx3_r <= mx2_r; my3_r <= my2_r; xn3_r <= xn2_r; yn3_r <= yn2_r;

      if (sq3_r >= ls_w) begin
        nmag4_r <= sq3_r - ls_w;
        nn4_r   <= 1'b0;
      end else begin
        nmag4_r <= ls_w - sq3_r;
        nn4_r   <= 1'b1;
      end
      nz4_r <= (sq3_r == ls_w);
      if (sa_w >= b_w) begin
        mmag4_r <= sa_w - b_w;
        mn4_r   <= 1'b0;
      end else begin
        mmag4_r <= b_w - sa_w;
        mn4_r   <= 1'b1;
      end
      mz4_r <= (sa_w == b_w);
      mx4_r <= mx3_r; my4_r <= my3_r; xn4_r <= xn3_r; yn4_r <= yn3_r;

      reach5_r <= (nmag4_r <= NW'(den_in));
      if (nmag4_r <= NW'(den_in)) begin
        dm5_r <= den_in - nmag4_r[S_W-1:0];
        dp5_r <= (S_W+1)'(den_in) + (S_W+1)'(nmag4_r[S_W-1:0]);
      end else begin
        dm5_r <= '0;
        dp5_r <= '0;
      end
      nmag5_r <= nmag4_r; nz5_r <= nz4_r; nn5_r <= nn4_r;
      mmag5_r <= mmag4_r; mz5_r <= mz4_r; mn5_r <= mn4_r;
      mx5_r <= mx4_r; my5_r <= my4_r; xn5_r <= xn4_r; yn5_r <= yn4_r;

      d6_r     <= prod_w[D_W-1:0];
      reach6_r <= reach5_r;
      nmag6_r <= nmag5_r; nz6_r <= nz5_r; nn6_r <= nn5_r;
      mmag6_r <= mmag5_r; mz6_r <= mz5_r; mn6_r <= mn5_r;
      mx6_r <= mx5_r; my6_r <= my5_r; xn6_r <= xn5_r; yn6_r <= yn5_r;
    end
  end

  assign v_out     = v6_r;
  assign d_out     = d6_r;
  assign reach_out = reach6_r;
  assign nmag_out  = nmag6_r;
  assign nzero_out = nz6_r;
  assign nneg_out  = nn6_r;
  assign mmag_out  = mmag6_r;
  assign mzero_out = mz6_r;
  assign mneg_out  = mn6_r;
  assign mx_out    = mx6_r;
  assign my_out    = my6_r;
  assign xneg_out  = xn6_r;
  assign yneg_out  = yn6_r;

endmodule

`default_nettype wire

[src/tlik_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_isqrt
// Pipelined restoring integer square root, one root bit per stage, with a
// side word carried alongside.
// ----------------------------------------------------------------------------
module tlik_isqrt
  import tlik_pkg::*;
#(
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              v_in,
  input  wire logic [D_W-1:0]    d_in,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   v_out,
  output logic [S_W-1:0]         root_out,
  output logic [SIDE_W-1:0]      side_out
);

  logic              v_r    [1:S_W];
  logic [D_W-1:0]    rem_r  [1:S_W];
  logic [S_W-1:0]    root_r [1:S_W];
  logic [SIDE_W-1:0] side_r [1:S_W];

  for (genvar j = 0; j < S_W; j++) begin : g_stage
    localparam int B = S_W - 1 - j;
    logic              cv;
    logic [D_W-1:0]    crem;
    logic [S_W-1:0]    croot;
    logic [SIDE_W-1:0] cside;
    logic [D_W-1:0]    trial;

    if (j == 0) begin : g_first
      assign cv    = v_in;
      assign crem  = d_in;
      assign croot = '0;
      assign cside = side_in;
    end else begin : g_next
      assign cv    = v_r[j];
      assign crem  = rem_r[j];
      assign croot = root_r[j];
      assign cside = side_r[j];
    end

    assign trial = (D_W'(croot) << (B + 1)) | (D_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[j+1] <= cside;
        if (crem >= trial) begin
          rem_r[j+1]  <= crem - trial;
          root_r[j+1] <= croot | (S_W'(1) << B);
        end else begin
          rem_r[j+1]  <= crem;
          root_r[j+1] <= croot;
        end
      end
    end
  end

  assign v_out    = v_r[S_W];
  assign root_out = root_r[S_W];
  assign side_out = side_r[S_W];

endmodule

`default_nettype wire

[src/tlik_qatan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_qatan
// Pipelined whole-degree atan2: binary search over the tangent table, two
// stages per bit (split product, then compare), then sign and quadrant fix.
// ----------------------------------------------------------------------------
module tlik_qatan
  import tlik_pkg::*;
#(
  parameter int YW = 29,
  parameter int XW = 30
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    v_in,
  input  wire logic [YW-1:0]           ymag,
  input  wire logic [XW-1:0]           xmag,
  input  wire qsgn_t                   sgn,
  output logic                         v_out,
  output logic signed [ANG_W-1:0]      ang
);

  localparam int YQ  = YW + 14;
  localparam int CXW = YW + 8;
  localparam int MW  = (XW > CXW) ? XW : CXW;
  localparam int LO  = (CXW + 1) / 2;
  localparam int HI  = CXW - LO;
  localparam int PW  = TAN_W + CXW + 1;

  logic [MW-1:0] xext_w, cap_w;

  logic           vb_r   [0:K_W];
  logic [YQ-1:0]  yb_r   [0:K_W];
  logic [CXW-1:0] xb_r   [0:K_W];
  logic [K_W-1:0] kb_r   [0:K_W];
  qsgn_t          sb_r   [0:K_W];
  logic           nzb_r  [0:K_W];

  logic                va_r  [0:K_W-1];
  logic [YQ-1:0]       ya_r  [0:K_W-1];
  logic [CXW-1:0]      xa_r  [0:K_W-1];
  logic [K_W-1:0]      ka_r  [0:K_W-1];
  logic [K_W-1:0]      ca_r  [0:K_W-1];
  logic                ok_r  [0:K_W-1];
  qsgn_t               sa_r  [0:K_W-1];
  logic                nza_r [0:K_W-1];
  logic [TAN_W+LO-1:0] pl_r  [0:K_W-1];
  logic [TAN_W+HI-1:0] ph_r  [0:K_W-1];

  logic                    vo_r;
  logic signed [ANG_W-1:0] ang_r;

  assign xext_w = MW'(xmag);
  assign cap_w  = MW'(1) << (YW + 7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r[0] <= 1'b0;
    end else if (en) begin
      vb_r[0] <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yb_r[0]  <= YQ'(ymag) * YQ'(TAN_SCALE);
      xb_r[0]  <= (xext_w >= cap_w) ? cap_w[CXW-1:0] : xext_w[CXW-1:0];
      kb_r[0]  <= '0;
      sb_r[0]  <= sgn;
      nzb_r[0] <= (ymag != '0);
    end
  end

  for (genvar s = 0; s < K_W; s++) begin : g_step
    localparam int B = K_W - 1 - s;
    logic [K_W-1:0]   cand;
    logic             ok;
    logic [K_W-1:0]   idx;
    logic [TAN_W-1:0] tanv;
    logic [PW-1:0]    sum;

    assign cand = kb_r[s] | (K_W'(1) << B);
    assign ok   = (cand <= TAN_MAX_K);
    assign idx  = ok ? cand : '0;
    assign tanv = TAN_E4[idx];
    assign sum  = (PW'(ph_r[s]) << LO) + PW'(pl_r[s]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[s]   <= 1'b0;
        vb_r[s+1] <= 1'b0;
      end else if (en) begin
        va_r[s]   <= vb_r[s];
        vb_r[s+1] <= va_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pl_r[s]  <= tanv * xb_r[s][LO-1:0];
        ph_r[s]  <= tanv * xb_r[s][CXW-1:LO];
        ca_r[s]  <= cand;
        ok_r[s]  <= ok;
        ya_r[s]  <= yb_r[s];
        xa_r[s]  <= xb_r[s];
        ka_r[s]  <= kb_r[s];
        sa_r[s]  <= sb_r[s];
        nza_r[s] <= nzb_r[s];

        kb_r[s+1]  <= (ok_r[s] && (sum < PW'(ya_r[s]))) ? ca_r[s] : ka_r[s];
        yb_r[s+1]  <= ya_r[s];
        xb_r[s+1]  <= xa_r[s];
        sb_r[s+1]  <= sa_r[s];
        nzb_r[s+1] <= nza_r[s];
      end
    end
  end

  logic [K_W-1:0]          kf_w;
  logic                    neg_w;
  logic signed [ANG_W-1:0] u_w, q_w;

  always_comb begin
    if (sb_r[K_W].xzero) begin
      kf_w = nzb_r[K_W] ? TAN_MAX_K : '0;
    end else begin
      kf_w = kb_r[K_W];
    end
    neg_w = nzb_r[K_W] & (sb_r[K_W].yneg ^ sb_r[K_W].xneg);
    u_w   = signed'({{(ANG_W-K_W){1'b0}}, kf_w});
    if (neg_w) begin
      u_w = -u_w;
    end
    q_w = u_w;
    if (sb_r[K_W].xneg) begin
      q_w = (u_w > 0) ? u_w - ANG_180 : u_w + ANG_180;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= vb_r[K_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= q_w;
    end
  end

  assign v_out = vo_r;
  assign ang   = ang_r;

endmodule

`default_nettype wire

[tb/sv/two_link_inverse_kinematics_tb.sv]
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics_tb
// Drives target points through the inverse kinematics pipeline under random
// input gaps and output stalls. Every transfer is checked field by field
// against an in-bench integer predictor, across several link-length settings.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics_tb;
  import tlik_pkg::*;

  localparam int CW        = 16;
  localparam int LATENCY   = 52;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic signed [ANG_W-1:0] shoulder;
    logic signed [ELB_W-1:0] elbow;
    logic                    unreach;
  } joint_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [CW-1:0]   in_target_x = '0;
  logic signed [CW-1:0]   in_target_y = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [ANG_W-1:0] out_shoulder_angle;
  logic signed [ELB_W-1:0] out_elbow_angle;
  logic                   out_unreachable;
  logic                   cfg_we = 1'b0;
  logic [0:0]             cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  longint unsigned upper_len, lower_len;
  joint_t          joints_due[$];
  int              error_count = 0;
  int              idle_cycles = 0;
  int              burst_left = 0;
  int              stall_mode = 0;

  always #1 clk = ~clk;

  two_link_inverse_kinematics #(.COORD_WIDTH(CW)) u_dut (.*);

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic int whole_deg_atan2(bit yneg, longint unsigned ymag, int xsgn,
                                         longint unsigned xmag);
    int k, u;
    bit neg;
    k = 0;
    if (xmag > (64'd1 << 40)) xmag = 64'd1 << 40;
    if (xsgn == 0) begin
      k = (ymag != 0) ? 90 : 0;
      neg = (ymag != 0) && yneg;
    end else begin
      for (int i = 1; i < 91; i++)
        if (longint'(TAN_E4[i]) * xmag < ymag * TAN_SCALE) k = i;
      neg = (ymag != 0) && (yneg != (xsgn < 0));
    end
    u = neg ? -k : k;
    if (xsgn < 0) u = (u > 0) ? u - 180 : u + 180;
    return u;
  endfunction

  function automatic joint_t solve_joints(logic signed [CW-1:0] tx, logic signed [CW-1:0] ty);
    joint_t j;
    longint unsigned mx, my, sq, a, b, ls, den, nmag, mmag, s;
    int nsgn, msgn, xsgn, elb, gam, base;
    bit reach;
    mx = tx < 0 ? longint'(-longint'(tx)) : longint'(tx);
    my = ty < 0 ? longint'(-longint'(ty)) : longint'(ty);
    sq = mx * mx + my * my;
    a = upper_len * upper_len;
    b = lower_len * lower_len;
    ls = a + b;
    den = 2 * upper_len * lower_len;
    if (sq >= ls) begin
      nmag = sq - ls;
      nsgn = (nmag != 0) ? 1 : 0;
    end else begin
      nmag = ls - sq;
      nsgn = -1;
    end
    if (sq + a >= b) begin
      mmag = sq + a - b;
      msgn = (mmag != 0) ? 1 : 0;
    end else begin
      mmag = b - (sq + a);
      msgn = -1;
    end
    reach = (nmag <= den);
    s = reach ? int_sqrt((den - nmag) * (den + nmag)) : 0;
    xsgn = (mx == 0) ? 0 : (tx < 0 ? -1 : 1);
    elb = whole_deg_atan2(1'b1, s, nsgn, nmag);
    gam = whole_deg_atan2(1'b1, s, msgn, mmag);
    base = whole_deg_atan2(ty < 0, my, xsgn, mx);
    j.shoulder = ANG_W'(base - gam);
    j.elbow = ELB_W'(elb);
    j.unreach = ~reach;
    return j;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    error_count++;
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    joint_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (joints_due.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        want = joints_due.pop_front();
        if (out_shoulder_angle !== want.shoulder)
          report_mismatch("shoulder", out_shoulder_angle, want.shoulder);
        if (out_elbow_angle !== want.elbow)
          report_mismatch("elbow", out_elbow_angle, want.elbow);
        if (out_unreachable !== want.unreach)
          report_mismatch("unreachable", out_unreachable, want.unreach);
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("two_link_inverse_kinematics_tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_target(logic signed [CW-1:0] tx, logic signed [CW-1:0] ty);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_target_x <= tx;
    in_target_y <= ty;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    joints_due.push_back(solve_joints(tx, ty));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (joints_due.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic set_links(int unsigned up, int unsigned low);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_UPPER;
    cfg_data <= CFG_W'(up);
    @(negedge clk);
    cfg_index <= CFG_LOWER;
    cfg_data <= CFG_W'(low);
    @(negedge clk);
    cfg_we <= 1'b0;
    upper_len = up;
    lower_len = low;
  endtask

  task automatic test_directed();
    send_target(0, 0);
    send_target(16'sh7FFF, 0);
    send_target(-16'sh8000, 0);
    send_target(0, 16'sh7FFF);
    send_target(0, -16'sh8000);
    send_target(-16'sh8000, -16'sh8000);
    send_target(16'sh7FFF, 16'sh7FFF);
    send_target(-16'sh8000, 16'sh7FFF);
    send_target(16'sh7FFF, -16'sh8000);
    send_target(4260, 0);
    send_target(-4260, 0);
    send_target(820, 0);
    send_target(0, -820);
    send_target(3000, 1500);
    send_target(-3000, 1500);
    send_target(-3000, -1500);
    send_target(3000, -1500);
    send_target(1, 1);
    send_target(-1, -1);
    send_target(2000, 3);
  endtask

  // mostly points within or near reach, some anywhere (all anywhere once reach exceeds 30000)
  task automatic test_random(int count);
    int reach_r, r, ang;
    logic signed [CW-1:0] tx, ty;
    reach_r = int'(upper_len + lower_len);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0 || reach_r > 30000) begin
        tx = CW'($urandom);
        ty = CW'($urandom);
      end else begin
        r = $urandom_range(0, reach_r + reach_r / 8);
        ang = $urandom_range(0, 3);
        tx = CW'($urandom_range(0, r));
        ty = CW'(int_sqrt(longint'(r) * r - longint'(tx) * tx));
        if (ang[0]) tx = -tx;
        if (ang[1]) ty = -ty;
      end
      send_target(tx, ty);
    end
  endtask

  initial begin
    upper_len = UPPER_RESET;
    lower_len = LOWER_RESET;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(300);
    set_links(16383, 16383);
    test_directed();
    test_random(200);
    set_links(1, 1);
    test_random(150);
    set_links(1, 16383);
    test_random(150);
    set_links(12000, 300);
    test_directed();
    test_random(200);
    set_links($urandom_range(1, 16383), $urandom_range(1, 16383));
    test_random(150);
    set_links(1720, 2540);
    test_random(120);
    drain();
    if (error_count == 0) begin
      $display("two_link_inverse_kinematics_tb: clean");
    end else begin
      $display("two_link_inverse_kinematics_tb: errors");
    end
    $finish;
  end

endmodule

[sim.f]
src/tlik_pkg.sv
src/tlik_prep.sv
src/tlik_isqrt.sv
src/tlik_qatan.sv
src/two_link_inverse_kinematics.sv
tb/sv/two_link_inverse_kinematics_tb.sv
